[sv/dtr_pkg.sv]
`timescale 1ns / 1ps

package dtr_pkg;

  // Request kinds
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;

  // Register selects
  localparam logic [1:0] SEL_DIV  = 2'd0;
  localparam logic [1:0] SEL_TIMA = 2'd1;
  localparam logic [1:0] SEL_TMA  = 2'd2;
  localparam logic [1:0] SEL_TAC  = 2'd3;

  // Overflow pending / reload window length in ticks
  localparam logic [2:0] PIPE_DELAY = 3'd4;
  localparam logic [7:0] TIMA_MAX   = 8'hFF;
  localparam logic [7:0] TAC_FILL   = 8'hF8;
  localparam logic [2:0] TAC_MASK   = 3'h7;

  typedef struct packed {
    logic [1:0] req_type;
    logic [1:0] reg_select;
    logic [7:0] write_data;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       timer_irq;
  } result_t;

  typedef struct packed {
    logic [15:0] sys_cnt;
    logic [7:0]  tima;
    logic [7:0]  tma;
    logic [2:0]  tac;
    logic        ovf_wait;
    logic [2:0]  ovf_cnt;
    logic        reload_win;
    logic [2:0]  reload_cnt;
  } timer_state_t;

  // Enabled counter tap: bit 9, 3, 5 or 7 of the system counter
  function automatic logic count_input(input logic [15:0] cnt, input logic [2:0] ctl);
    logic tap;
    unique case (ctl[1:0])
      2'd0: tap = cnt[9];
      2'd1: tap = cnt[3];
      2'd2: tap = cnt[5];
      default: tap = cnt[7];
    endcase
    return ctl[2] & tap;
  endfunction

endpackage

[sv/dtr_state.sv]
`timescale 1ns / 1ps

module dtr_state (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  dtr_pkg::item_t  item,
  output dtr_pkg::result_t result
);
  import dtr_pkg::*;

  timer_state_t st;
  timer_state_t st_next;

  // One TIMA step, swallowed while overflow is pending or in reload window
  function automatic timer_state_t count_edge(input timer_state_t s);
    timer_state_t r;
    r = s;
    if (!s.ovf_wait && !s.reload_win) begin
      if (s.tima == TIMA_MAX) begin
        r.tima     = '0;
        r.ovf_wait = 1'b1;
        r.ovf_cnt  = PIPE_DELAY;
      end else begin
        r.tima = s.tima + 8'd1;
      end
    end
    return r;
  endfunction

  always_comb begin
    timer_state_t s;
    logic tap_old;
    logic after;
    logic irq;
    logic [7:0] rd;
    s       = st;
    irq     = 1'b0;
    rd      = '0;
    tap_old = count_input(st.sys_cnt, st.tac);
    after   = 1'b0;
    unique case (item.req_type)
      REQ_TICK: begin
        if (s.ovf_wait) begin
          if (s.ovf_cnt != 3'd0) begin
            s.ovf_cnt = s.ovf_cnt - 3'd1;
            if (s.ovf_cnt == 3'd0) begin
              s.ovf_wait   = 1'b0;
              s.reload_win = 1'b1;
              s.reload_cnt = PIPE_DELAY;
              s.tima       = s.tma;
              irq          = 1'b1;
            end
          end
        end else if (s.reload_win) begin
          if (s.reload_cnt != 3'd0) begin
            s.reload_cnt = s.reload_cnt - 3'd1;
            if (s.reload_cnt == 3'd0) begin
              s.reload_win = 1'b0;
            end
          end
        end
        s.sys_cnt = s.sys_cnt + 16'd1;
        after = count_input(s.sys_cnt, s.tac);
        if (tap_old && !after) begin
          s = count_edge(s);
        end
      end
      REQ_READ: begin
        unique case (item.reg_select)
          SEL_DIV:  rd = st.sys_cnt[15:8];
          SEL_TIMA: rd = st.tima;
          SEL_TMA:  rd = st.tma;
          default:  rd = TAC_FILL | {5'd0, st.tac};
        endcase
      end
      REQ_WRITE: begin
        unique case (item.reg_select)
          SEL_DIV: begin
            s.sys_cnt = '0;
            after = count_input(s.sys_cnt, s.tac);
            if (tap_old && !after) begin
              s = count_edge(s);
            end
          end
          SEL_TIMA: begin
            if (!s.reload_win) begin
              s.tima = item.write_data;
              if (s.ovf_wait) begin
                s.ovf_wait = 1'b0;
                s.ovf_cnt  = '0;
              end
            end
          end
          SEL_TMA: begin
            s.tma = item.write_data;
            if (s.reload_win) begin
              s.tima = item.write_data;
            end
          end
          default: begin
            s.tac = item.write_data[2:0] & TAC_MASK;
            after = count_input(s.sys_cnt, s.tac);
            if (tap_old && !after) begin
              s = count_edge(s);
            end
          end
        endcase
      end
      default: begin
        s = st;
      end
    endcase
    st_next          = s;
    result.read_data = rd;
    result.timer_irq = irq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (fire) begin
      st <= st_next;
    end
  end

  // pending phase and reload window never overlap
  a_phase_excl: assert property (@(posedge clk) disable iff (rst)
    !(st.ovf_wait && st.reload_win))
    else $error("overflow pending and reload window both active");

  // countdowns stay live exactly while their phase is active
  a_ovf_cnt: assert property (@(posedge clk) disable iff (rst)
    st.ovf_wait == (st.ovf_cnt != 3'd0))
    else $error("overflow countdown out of step with pending flag");

  a_reload_cnt: assert property (@(posedge clk) disable iff (rst)
    !st.reload_win || (st.reload_cnt != 3'd0))
    else $error("reload window open with empty countdown");

  // an interrupt beat opens the reload window with TMA loaded into TIMA
  a_irq_reload: assert property (@(posedge clk) disable iff (rst)
    (fire && result.timer_irq) |=> (st.reload_win && st.reload_cnt == PIPE_DELAY
                                   && st.tima == $past(st.tma)))
    else $error("interrupt without reload");

endmodule

[sv/divider_timer_with_reload_core.sv]
`timescale 1ns / 1ps

// Divider/timer with reload (DIV, TIMA, TMA, TAC). Every input beat is a
// timer tick, a register read, a register write or an unused code that
// changes nothing, and every beat yields exactly one result beat (read_data,
// timer_irq). Throughput is one beat per clock while the output side is not
// stalled: an input register feeds the timer state update, which fills an
// output register, and the result beat is taken once it is valid and the
// output side is not stalled. The single state update path between the input
// and output registers sets that rate. A stall on the output side holds the
// result and backs up into the input register, so at most two beats sit
// inside the block. TIMA overflow reads as zero for four ticks, then reloads
// from TMA and flags timer_irq on that tick's result.
module divider_timer_with_reload_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] req_type,
  input  logic [1:0] reg_select,
  input  logic [7:0] write_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_data,
  output logic       timer_irq
);
  import dtr_pkg::*;

  // input register
  logic    in_full;
  item_t   in_item;
  // output register
  result_t res;
  result_t res_comb;

  logic out_free;
  logic advance;
  logic in_take;

  // output slot opens when empty or being drained this cycle
  assign out_free = !out_valid || !out_stall;
  assign advance  = in_full && out_free;
  assign in_stall = in_full && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item <= '{req_type: req_type, reg_select: reg_select, write_data: write_data};
    end
  end

  // state update: commits when the beat moves into the output register
  dtr_state u_state (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (in_item),
    .result (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_comb;
    end
  end

  assign read_data = res.read_data;
  assign timer_irq = res.timer_irq;

  // a held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(read_data) && $stable(timer_irq)))
    else $error("stalled result changed");

  // the input register only blocks when the output side is backed up
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall && in_full))
    else $error("input stalled without output backpressure");

  // every advanced beat shows up as a valid result
  a_advance_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advanced beat lost");

endmodule

[tb/sv/divider_timer_with_reload_core_tb.sv]
`timescale 1ns / 1ps

// Self-checking bench for the DIV/TIMA/TMA/TAC timer core.
module divider_timer_with_reload_core_tb;
  import dtr_pkg::*;

  // Request code that the core must swallow without touching state
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // Counter bit tapped per TAC rate select, 4 bits per entry: 9, 3, 5, 7
  localparam logic [15:0] TAP_TABLE = {4'd7, 4'd5, 4'd3, 4'd9};

  localparam int RANDOM_BEATS = 1100;
  localparam int LIMIT_CYCLES = 200000;

  // Timer predictor plus queue of results still owed by the core
  class timer_scoreboard;
    logic [15:0] sys_count;
    logic [7:0]  tima;
    logic [7:0]  tma;
    logic [2:0]  tac;
    bit          ovf_pending;
    logic [2:0]  ovf_left;
    bit          reload_open;
    logic [2:0]  reload_left;
    result_t     due_results[$];
    int          errors;

    function new();
      sys_count   = '0;
      tima        = '0;
      tma         = '0;
      tac         = '0;
      ovf_pending = 1'b0;
      ovf_left    = '0;
      reload_open = 1'b0;
      reload_left = '0;
      errors      = 0;
    endfunction

    function bit tap_high(logic [15:0] cnt, logic [2:0] ctl);
      logic [3:0] pos;
      pos = TAP_TABLE[ctl[1:0]*4 +: 4];
      return ctl[2] && cnt[pos];
    endfunction

    // One TIMA step; dropped while an overflow is pending or reloading
    function void count_step();
      if (ovf_pending || reload_open) return;
      if (tima == TIMA_MAX) begin
        tima        = '0;
        ovf_pending = 1'b1;
        ovf_left    = PIPE_DELAY;
      end else begin
        tima = tima + 8'd1;
      end
    endfunction

    // Pending countdown, then reload window countdown; returns the irq
    function bit age_overflow();
      bit irq;
      irq = 1'b0;
      if (ovf_pending) begin
        if (ovf_left != 0) begin
          ovf_left = ovf_left - 3'd1;
          if (ovf_left == 0) begin
            ovf_pending = 1'b0;
            reload_open = 1'b1;
            reload_left = PIPE_DELAY;
            tima        = tma;
            irq         = 1'b1;
          end
        end
      end else if (reload_open) begin
        if (reload_left != 0) begin
          reload_left = reload_left - 3'd1;
          if (reload_left == 0) reload_open = 1'b0;
        end
      end
      return irq;
    endfunction

    function void note_input(logic [1:0] rq, logic [1:0] sl, logic [7:0] wd);
      result_t exp;
      bit      was_high;
      exp      = '0;
      was_high = tap_high(sys_count, tac);
      case (rq)
        REQ_TICK: begin
          exp.timer_irq = age_overflow();
          sys_count     = sys_count + 16'd1;
          if (was_high && !tap_high(sys_count, tac)) count_step();
        end
        REQ_READ: begin
          case (sl)
            SEL_DIV:  exp.read_data = sys_count[15:8];
            SEL_TIMA: exp.read_data = tima;
            SEL_TMA:  exp.read_data = tma;
            default:  exp.read_data = TAC_FILL | {5'd0, tac};
          endcase
        end
        REQ_WRITE: begin
          case (sl)
            SEL_DIV: begin
              sys_count = '0;
              if (was_high && !tap_high(sys_count, tac)) count_step();
            end
            SEL_TIMA: begin
              // ignored in the reload window, cancels a pending reload
              if (!reload_open) begin
                tima = wd;
                if (ovf_pending) begin
                  ovf_pending = 1'b0;
                  ovf_left    = '0;
                end
              end
            end
            SEL_TMA: begin
              tma = wd;
              if (reload_open) tima = tma;
            end
            default: begin
              tac = wd[2:0] & TAC_MASK;
              if (was_high && !tap_high(sys_count, tac)) count_step();
            end
          endcase
        end
        default: ;
      endcase
      due_results.push_back(exp);
    endfunction

    function void check_result(logic [7:0] rd, logic irq);
      result_t exp;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, actual read_data %h timer_irq %b",
                 $time, rd, irq);
        return;
      end
      exp = due_results.pop_front();
      if (rd !== exp.read_data) begin
        errors++;
        $display("%0t: read_data expected %h actual %h", $time, exp.read_data, rd);
      end
      if (irq !== exp.timer_irq) begin
        errors++;
        $display("%0t: timer_irq expected %b actual %b", $time, exp.timer_irq, irq);
      end
    endfunction
  endclass

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       in_valid   = 1'b0;
  logic       in_stall;
  logic [1:0] req_type   = '0;
  logic [1:0] reg_select = '0;
  logic [7:0] write_data = '0;
  logic       out_valid;
  logic       out_stall  = 1'b0;
  logic [7:0] read_data;
  logic       timer_irq;

  // steady: both sides stop idling for a stretch of the random part
  bit steady      = 1'b0;
  int beats_sent  = 0;
  int cycle_count = 0;

  timer_scoreboard sb = new();

  divider_timer_with_reload_core u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .reg_select (reg_select),
    .write_data (write_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_data  (read_data),
    .timer_irq  (timer_irq)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: random stall, driven at the rising edge
  always @(posedge clk) begin
    out_stall <= !rst && !steady && ($urandom_range(99) < 37);
  end

  // Both channels are sampled mid-cycle; TB inputs only move at rising edges,
  // so these are the values the core sees at the next edge.
  always @(negedge clk) begin
    if (!rst && in_valid && !in_stall) sb.note_input(req_type, reg_select, write_data);
    if (!rst && out_valid && !out_stall) sb.check_result(read_data, timer_irq);
  end

  // Drive one beat and return at the edge that accepts it. valid stays high
  // on return, so back-to-back beats keep the channel busy.
  task automatic send_beat(input logic [1:0] rq, input logic [1:0] sl, input logic [7:0] wd);
    bit taken;
    while (!steady && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= rq;
    reg_select <= sl;
    write_data <= wd;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    if (rq != REQ_UNUSED) beats_sent++;
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_beat(REQ_TICK, 2'($urandom), 8'($urandom));
  endtask

  // Hold the sender until every owed result has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
  endtask

  // Register access mixed into an overflow run; TIMA writes lean high so
  // they keep overflows coming, and DIV resets stay rare.
  task automatic body_access();
    int pick;
    pick = $urandom_range(99);
    if (pick < 45)
      send_beat(REQ_READ, 2'($urandom), 8'($urandom));
    else if (pick < 55)
      send_beat(REQ_WRITE, SEL_TIMA, 8'($urandom));
    else if (pick < 70)
      send_beat(REQ_WRITE, SEL_TIMA, 8'($urandom_range(255, 250)));
    else if (pick < 88)
      send_beat(REQ_WRITE, SEL_TMA, 8'($urandom));
    else if (pick < 97)
      send_beat(REQ_WRITE, SEL_TAC, 8'($urandom));
    else
      send_beat(REQ_WRITE, SEL_DIV, 8'($urandom));
  endtask

  // Well-formed overflow sequence: load TMA, park TIMA near the top,
  // enable a fast rate, then mostly ticks so reloads and irqs happen.
  task automatic overflow_run();
    logic [1:0] rate;
    int         n;
    // rate 1 taps bit 3, the fastest; others now and then
    rate = ($urandom_range(99) < 70) ? 2'd1 : 2'($urandom);
    send_beat(REQ_WRITE, SEL_TMA, 8'($urandom));
    send_beat(REQ_WRITE, SEL_TIMA, 8'($urandom_range(255, 253)));
    send_beat(REQ_WRITE, SEL_TAC, {5'($urandom), 1'b1, rate});
    n = $urandom_range(70, 30);
    repeat (n) begin
      if ($urandom_range(99) < 80) send_ticks(1);
      else body_access();
    end
  endtask

  // Long tick run with no DIV reset so the upper counter bits move
  // (DIV reads above zero, the bit 9 tap).
  task automatic long_count();
    int n;
    send_beat(REQ_WRITE, SEL_TAC, 8'($urandom));
    n = $urandom_range(250, 100);
    repeat (n) begin
      if ($urandom_range(99) < 90) send_ticks(1);
      else send_beat(REQ_READ, 2'($urandom), 8'($urandom));
    end
  endtask

  // Anything goes, unused request code included
  task automatic noise_burst();
    repeat ($urandom_range(6, 1))
      send_beat(2'($urandom), 2'($urandom), 8'($urandom));
  endtask

  initial begin
    int kind;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset TAC readback, masked TAC write, falling edges from a
    // TAC write and from a DIV reset, overflow into the pending phase,
    // reload with irq, TMA passthrough and ignored TIMA write in the
    // reload window, DIV read, unused request.
    send_beat(REQ_READ, SEL_TAC, 8'h00);
    send_beat(REQ_WRITE, SEL_TMA, 8'hAB);
    send_beat(REQ_WRITE, SEL_TIMA, 8'hFE);
    send_beat(REQ_WRITE, SEL_TAC, 8'hFD);      // enable, bit 3 tap
    send_beat(REQ_READ, SEL_TAC, 8'hFF);
    send_ticks(8);                             // bit 3 now high
    send_beat(REQ_WRITE, SEL_TAC, 8'hFF);      // to bit 7: edge, TIMA FF
    send_beat(REQ_WRITE, SEL_TAC, 8'h05);      // back to bit 3, no edge
    send_beat(REQ_WRITE, SEL_DIV, 8'hFF);      // counter clear: overflow
    send_beat(REQ_READ, SEL_TIMA, 8'h00);      // reads zero while pending
    send_ticks(4);                             // reload, irq on the last
    send_beat(REQ_WRITE, SEL_TMA, 8'h5A);      // copied into TIMA
    send_beat(REQ_WRITE, SEL_TIMA, 8'h11);     // dropped in reload window
    send_beat(REQ_READ, SEL_TIMA, 8'h00);
    send_beat(REQ_READ, SEL_DIV, 8'h00);
    send_beat(REQ_UNUSED, SEL_TMA, 8'hFF);

    drain();
    beats_sent = 0;

    while (beats_sent < RANDOM_BEATS) begin
      steady = (beats_sent >= 400 && beats_sent < 600);
      kind   = $urandom_range(99);
      if (kind < 65) overflow_run();
      else if (kind < 75) long_count();
      else noise_burst();
    end
    steady = 1'b0;

    drain();
    // catch any stray extra beat
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.due_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
